// ----- hdl/sd_spi_card_init_engine_core_macros.svh -----
// Assertion macros shared by the SD card SPI init engine.
`ifndef SD_SPI_CARD_INIT_ENGINE_CORE_MACROS_SVH
`define SD_SPI_CARD_INIT_ENGINE_CORE_MACROS_SVH

// Checks that a condition implies another in the same cycle.
`define SDI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Checks that a condition implies another in the following cycle.
`define SDI_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- hdl/sdi_pkg.sv -----
// Types, constants and command frames of the SD card SPI init engine.
package sdi_pkg;

	localparam int WAKE_BYTES_DEF = 8;

	localparam logic [1:0] OUT_READY   = 2'd0;
	localparam logic [1:0] OUT_IO_ERR  = 2'd1;
	localparam logic [1:0] OUT_NO_IDLE = 2'd2;

	localparam logic [2:0] KIND_UNKNOWN  = 3'd0;
	localparam logic [2:0] KIND_SDV1     = 3'd1;
	localparam logic [2:0] KIND_SDV2_BYTE = 3'd2;
	localparam logic [2:0] KIND_SDV2_BLK = 3'd3;
	localparam logic [2:0] KIND_MMCV3    = 3'd4;

	localparam logic OP_START  = 1'b0;
	localparam logic OP_REPORT = 1'b1;

	localparam logic [1:0] REG_READY_LIM = 2'd0;
	localparam logic [1:0] REG_RESP_LIM  = 2'd1;
	localparam logic [1:0] REG_RETRY_LIM = 2'd2;
	localparam logic [1:0] REG_TOKEN_LIM = 2'd3;

	localparam logic [7:0] BYTE_IDLE  = 8'hFF;
	localparam logic [7:0] BYTE_TOKEN = 8'hFE;
	localparam logic [7:0] CHECK_PAT  = 8'hAA;

	typedef enum logic [3:0] {
		PH_IDLE, PH_WAKE, PH_CMD0, PH_CMD8, PH_A55, PH_A41,
		PH_CMD1, PH_CMD58, PH_CMD16, PH_CMD9
	} phase_t;

	typedef enum logic [2:0] {
		SB_READY, SB_FRAME, SB_RESP, SB_RSP, SB_DUMMY, SB_TOKEN, SB_DATA, SB_CRC
	} sub_t;

	typedef struct packed {
		logic       op;
		logic [7:0] rx_byte;
	} req_t;

	typedef struct packed {
		logic [7:0]  tx_byte;
		logic        chip_select;
		logic        done_res;
		logic [1:0]  outcome;
		logic [2:0]  card_kind;
		logic [32:0] sector_total;
	} res_t;

	typedef struct packed {
		logic [15:0] ready_wait_limit;
		logic [15:0] response_wait_limit;
		logic [7:0]  init_retry_limit;
		logic [15:0] token_wait_limit;
	} cfg_t;

	function automatic logic [47:0] make_frame(input logic [5:0] cmd, input logic [31:0] arg);
		logic [47:0] f;
		logic [6:0]  crc;
		logic [7:0]  d;
		f = {2'b01, cmd, arg, 8'h00};
		crc = '0;
		for (int k = 0; k < 5; k++) begin
			d = f[47 - 8 * k -: 8];
			for (int i = 0; i < 8; i++) begin
				if (d[7] ^ crc[6]) begin
					crc = {crc[5:0], 1'b0} ^ 7'h09;
				end else begin
					crc = {crc[5:0], 1'b0};
				end
				d = {d[6:0], 1'b0};
			end
		end
		f[7:0] = {crc, 1'b1};
		return f;
	endfunction

	localparam logic [47:0] FRM_CMD0  = make_frame(6'd0, 32'd0);
	localparam logic [47:0] FRM_CMD8  = make_frame(6'd8, 32'h1AA);
	localparam logic [47:0] FRM_A55   = make_frame(6'd55, 32'd0);
	localparam logic [47:0] FRM_A41   = make_frame(6'd41, 32'h4000_0000);
	localparam logic [47:0] FRM_CMD1  = make_frame(6'd1, 32'h4000_0000);
	localparam logic [47:0] FRM_CMD58 = make_frame(6'd58, 32'h1AA);
	localparam logic [47:0] FRM_CMD16 = make_frame(6'd16, 32'd512);
	localparam logic [47:0] FRM_CMD9  = make_frame(6'd9, 32'd0);

	function automatic logic [47:0] frame_of(input phase_t ph);
		logic [47:0] f;
		case (ph)
			PH_CMD0:  f = FRM_CMD0;
			PH_CMD8:  f = FRM_CMD8;
			PH_A55:   f = FRM_A55;
			PH_A41:   f = FRM_A41;
			PH_CMD1:  f = FRM_CMD1;
			PH_CMD58: f = FRM_CMD58;
			PH_CMD16: f = FRM_CMD16;
			PH_CMD9:  f = FRM_CMD9;
			default:  f = FRM_CMD0;
		endcase
		return f;
	endfunction

endpackage

// ----- hdl/sd_spi_card_init_engine_core.sv -----
// Top level of the SD card SPI init engine: register port, request and result registers.
// A request is held in the input register, then stepped into the result register.
// Throughput: one request per cycle; the sequencer step is single-pass logic.
// Stalls on the result side hold one request in the input register.
// Reset clears all control state, the limits to 100, 1000, 32 and 100,
// and the last report to "card never entered idle".
module sd_spi_card_init_engine_core #(
	parameter int WAKE_BYTES = sdi_pkg::WAKE_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  sdi_pkg::req_t in_req,
	output logic          out_valid,
	input  logic          out_ready,
	output sdi_pkg::res_t out_res,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import sdi_pkg::*;
	`include "sd_spi_card_init_engine_core_macros.svh"

	cfg_t  cfg_q;
	logic  valid_s1;
	req_t  req_s1;
	logic  out_valid_q;
	res_t  out_q;
	res_t  step_res;
	logic  advance;
	logic  wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;

	always_comb begin
		case (paddr[3:2])
			REG_READY_LIM: prdata = {16'd0, cfg_q.ready_wait_limit};
			REG_RESP_LIM:  prdata = {16'd0, cfg_q.response_wait_limit};
			REG_RETRY_LIM: prdata = {24'd0, cfg_q.init_retry_limit};
			REG_TOKEN_LIM: prdata = {16'd0, cfg_q.token_wait_limit};
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{ready_wait_limit: 16'd100, response_wait_limit: 16'd1000,
				init_retry_limit: 8'd32, token_wait_limit: 16'd100};
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_READY_LIM: cfg_q.ready_wait_limit    <= pwdata[15:0];
				REG_RESP_LIM:  cfg_q.response_wait_limit <= pwdata[15:0];
				REG_RETRY_LIM: cfg_q.init_retry_limit    <= pwdata[7:0];
				REG_TOKEN_LIM: cfg_q.token_wait_limit    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= in_req;
		end
		if (advance) begin
			out_q <= step_res;
		end
	end

	sdi_seq #(.WAKE_BYTES(WAKE_BYTES)) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.req    (req_s1),
		.cfg    (cfg_q),
		.res    (step_res)
	);

	`SDI_ASSERT_IMP(a_done_idle_bus, out_valid_q && out_q.done_res, out_q.tx_byte == BYTE_IDLE && out_q.chip_select)
	`SDI_ASSERT_IMP(a_busy_no_report, out_valid_q && !out_q.done_res, out_q.outcome == OUT_READY && out_q.card_kind == KIND_UNKNOWN && out_q.sector_total == 33'd0)
	`SDI_ASSERT_NXT(a_accept_loads, in_valid && in_ready, valid_s1)

endmodule

// ----- hdl/sdi_seq.sv -----
// Card identification sequencer: state, per-byte step logic and CSD decode.
module sdi_seq #(
	parameter int WAKE_BYTES = sdi_pkg::WAKE_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  sdi_pkg::req_t req,
	input  sdi_pkg::cfg_t cfg,
	output sdi_pkg::res_t res
);
	import sdi_pkg::*;

	localparam int WB = $clog2(WAKE_BYTES + 1);
	localparam int BW = (WB > 5) ? WB : 5;

	phase_t      phase_q, phase_n;
	sub_t        sub_q, sub_n;
	logic [47:0] frame_q, frame_n;
	logic [BW-1:0] idx_q, idx_n, idx_inc;
	logic [15:0] wait_q, wait_n, wait_dec;
	logic [7:0]  retry_q, retry_n, retry_dec;
	logic [31:0] ocr_q, ocr_n;
	logic [7:0]  csd_q [16];
	logic        csd_wr, csd_clr;
	logic [2:0]  class_q, class_n;
	logic [7:0]  r1_q, r1_n, r1_eff;
	logic        v2_q, v2_n;
	logic [1:0]  rep_out_q, rep_out_n;
	logic [2:0]  rep_kind_q, rep_kind_n;
	logic [32:0] rep_sec_q, rep_sec_n;

	// command completion decisions
	logic        cd_start, cd_fin;
	phase_t      cd_ph;
	logic [1:0]  cd_out;
	logic [2:0]  cd_class;
	logic        cd_v2;
	logic [7:0]  cd_retry;

	logic        do_start, do_fin, do_report;
	phase_t      st_ph;
	logic [1:0]  fin_out;
	logic [7:0]  tx_n;
	logic        cs_n;
	logic [32:0] csd_sectors;

	logic [22:0] v_hc;
	logic [12:0] v_sc;
	logic [4:0]  n_sc;

	assign idx_inc   = idx_q + 1'b1;
	assign wait_dec  = wait_q - 1'b1;
	assign retry_dec = retry_q - 1'b1;
	assign r1_eff    = (sub_q == SB_RESP) ? req.rx_byte : r1_q;

	always_comb begin
		v_hc = {1'b0, csd_q[7][5:0], csd_q[8], csd_q[9]} + 23'd1;
		v_sc = {1'b0, csd_q[6][1:0], csd_q[7], csd_q[8][7:6]} + 13'd1;
		n_sc = {1'b0, csd_q[5][3:0]} + {4'd0, csd_q[10][7]} + {2'd0, csd_q[9][1:0], 1'b0} + 5'd2;
		if (csd_q[0][7:6] == 2'd1) begin
			csd_sectors = {v_hc, 10'd0};
		end else if (n_sc >= 5'd9) begin
			csd_sectors = {20'd0, v_sc} << (n_sc - 5'd9);
		end else begin
			csd_sectors = {20'd0, v_sc >> (5'd9 - n_sc)};
		end
	end

	always_comb begin
		cd_start = 1'b0;
		cd_fin   = 1'b0;
		cd_ph    = PH_CMD0;
		cd_out   = OUT_READY;
		cd_class = class_q;
		cd_v2    = v2_q;
		cd_retry = retry_q;
		case (phase_q)
			PH_CMD0: begin
				if (r1_eff == 8'd1) begin
					cd_start = 1'b1;
					cd_ph = PH_CMD8;
				end else begin
					cd_fin = 1'b1;
					cd_out = OUT_NO_IDLE;
				end
			end
			PH_CMD8: begin
				cd_retry = cfg.init_retry_limit;
				if (r1_eff == 8'd1 && (ocr_q[15:8] != 8'h01 || ocr_q[7:0] != CHECK_PAT)) begin
					cd_fin = 1'b1;
					cd_out = OUT_IO_ERR;
				end else begin
					cd_v2 = (r1_eff == 8'd1);
					cd_start = 1'b1;
					cd_ph = PH_A55;
				end
			end
			PH_A55: begin
				cd_start = 1'b1;
				cd_ph = PH_A41;
			end
			PH_A41: begin
				cd_retry = retry_dec;
				if (r1_eff == 8'd0) begin
					cd_start = 1'b1;
					if (v2_q) begin
						cd_ph = PH_CMD58;
					end else begin
						cd_class = KIND_SDV1;
						cd_ph = PH_CMD16;
					end
				end else if (retry_dec != 8'd0) begin
					cd_start = 1'b1;
					cd_ph = PH_A55;
				end else if (v2_q) begin
					cd_fin = 1'b1;
					cd_out = OUT_IO_ERR;
				end else begin
					cd_retry = cfg.init_retry_limit;
					cd_start = 1'b1;
					cd_ph = PH_CMD1;
				end
			end
			PH_CMD1: begin
				cd_retry = retry_dec;
				if (r1_eff == 8'd0) begin
					cd_class = KIND_MMCV3;
					cd_start = 1'b1;
					cd_ph = PH_CMD16;
				end else if (retry_dec != 8'd0) begin
					cd_start = 1'b1;
					cd_ph = PH_CMD1;
				end else begin
					cd_fin = 1'b1;
					cd_out = OUT_IO_ERR;
				end
			end
			PH_CMD58: begin
				if (r1_eff != 8'd0) begin
					cd_fin = 1'b1;
					cd_out = OUT_IO_ERR;
				end else if (ocr_q[30]) begin
					cd_class = KIND_SDV2_BLK;
					cd_start = 1'b1;
					cd_ph = PH_CMD9;
				end else begin
					cd_class = KIND_SDV2_BYTE;
					cd_start = 1'b1;
					cd_ph = PH_CMD16;
				end
			end
			PH_CMD16: begin
				cd_start = 1'b1;
				cd_ph = PH_CMD9;
			end
			default: begin
				cd_fin = 1'b1;
				cd_out = OUT_READY;
			end
		endcase
	end

	// Next-state logic.
	always_comb begin
		phase_n = phase_q;
		sub_n   = sub_q;
		frame_n = frame_q;
		idx_n   = idx_q;
		wait_n  = wait_q;
		retry_n = retry_q;
		ocr_n   = ocr_q;
		class_n = class_q;
		r1_n    = r1_q;
		v2_n    = v2_q;
		csd_wr  = 1'b0;
		do_start = 1'b0;
		do_fin   = 1'b0;
		do_report = 1'b0;
		st_ph    = PH_CMD0;
		fin_out  = OUT_READY;
		tx_n     = BYTE_IDLE;
		cs_n     = 1'b0;
		if (req.op == OP_START) begin
			class_n = KIND_UNKNOWN;
			phase_n = PH_WAKE;
			idx_n   = BW'(1);
			cs_n    = 1'b1;
		end else if (phase_q == PH_IDLE) begin
			do_report = 1'b1;
		end else if (phase_q == PH_WAKE) begin
			if (idx_q < BW'(WAKE_BYTES)) begin
				idx_n = idx_inc;
				cs_n  = 1'b1;
			end else begin
				do_start = 1'b1;
				st_ph = PH_CMD0;
			end
		end else begin
			case (sub_q)
				SB_READY: begin
					wait_n = wait_dec;
					if (!(req.rx_byte != BYTE_IDLE && wait_dec != 16'd0)) begin
						sub_n = SB_FRAME;
						idx_n = BW'(1);
						tx_n  = frame_q[47:40];
					end
				end
				SB_FRAME: begin
					if (idx_q < BW'(6)) begin
						idx_n = idx_inc;
						case (idx_q[2:0])
							3'd1: tx_n = frame_q[39:32];
							3'd2: tx_n = frame_q[31:24];
							3'd3: tx_n = frame_q[23:16];
							3'd4: tx_n = frame_q[15:8];
							3'd5: tx_n = frame_q[7:0];
							default: tx_n = frame_q[47:40];
						endcase
					end else begin
						sub_n  = SB_RESP;
						wait_n = cfg.response_wait_limit;
					end
				end
				SB_RESP: begin
					wait_n = wait_dec;
					if (!(req.rx_byte[7] && wait_dec != 16'd0)) begin
						r1_n = req.rx_byte;
						if (phase_q == PH_CMD8 || phase_q == PH_CMD58) begin
							sub_n = SB_RSP;
							idx_n = '0;
						end else if (phase_q == PH_CMD9) begin
							sub_n  = SB_TOKEN;
							wait_n = cfg.token_wait_limit;
						end else begin
							do_start = cd_start;
							do_fin   = cd_fin;
						end
					end
				end
				SB_RSP: begin
					ocr_n = {ocr_q[23:0], req.rx_byte};
					idx_n = idx_inc;
					if (idx_inc >= BW'(4)) begin
						sub_n = SB_DUMMY;
						idx_n = '0;
					end
				end
				SB_TOKEN: begin
					wait_n = wait_dec;
					if (!(req.rx_byte == BYTE_IDLE && wait_dec != 16'd0)) begin
						if (req.rx_byte == BYTE_TOKEN) begin
							sub_n = SB_DATA;
							idx_n = '0;
						end else begin
							do_start = cd_start;
							do_fin   = cd_fin;
						end
					end
				end
				SB_DATA: begin
					csd_wr = 1'b1;
					idx_n  = idx_inc;
					if (idx_inc >= BW'(16)) begin
						sub_n = SB_CRC;
						idx_n = '0;
					end
				end
				default: begin
					idx_n = idx_inc;
					if (idx_inc >= BW'(2)) begin
						do_start = cd_start;
						do_fin   = cd_fin;
					end
				end
			endcase
			if (do_start || do_fin) begin
				st_ph   = cd_ph;
				class_n = cd_class;
				v2_n    = cd_v2;
				retry_n = cd_retry;
				fin_out = cd_out;
			end
		end
		if (do_start) begin
			phase_n = st_ph;
			frame_n = frame_of(st_ph);
			sub_n   = SB_READY;
			wait_n  = cfg.ready_wait_limit;
		end
		if (do_fin) begin
			phase_n = PH_IDLE;
			if (fin_out != OUT_READY) begin
				class_n = KIND_UNKNOWN;
			end
		end
	end

	assign csd_clr = do_start && (st_ph == PH_CMD9);

	// Output logic.
	always_comb begin
		rep_out_n  = rep_out_q;
		rep_kind_n = rep_kind_q;
		rep_sec_n  = rep_sec_q;
		if (do_fin) begin
			rep_out_n  = fin_out;
			rep_kind_n = (fin_out == OUT_READY) ? class_q : KIND_UNKNOWN;
			rep_sec_n  = (fin_out == OUT_READY) ? csd_sectors : 33'd0;
		end
		if (do_fin || do_report) begin
			res = '{tx_byte: BYTE_IDLE, chip_select: 1'b1, done_res: 1'b1,
				outcome: rep_out_n, card_kind: rep_kind_n, sector_total: rep_sec_n};
		end else begin
			res = '{tx_byte: tx_n, chip_select: cs_n, done_res: 1'b0,
				outcome: OUT_READY, card_kind: KIND_UNKNOWN, sector_total: 33'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			sub_q      <= SB_READY;
			frame_q    <= '0;
			idx_q      <= '0;
			wait_q     <= '0;
			retry_q    <= '0;
			class_q    <= KIND_UNKNOWN;
			r1_q       <= '0;
			v2_q       <= 1'b0;
			rep_out_q  <= OUT_NO_IDLE;
			rep_kind_q <= KIND_UNKNOWN;
			rep_sec_q  <= '0;
			for (int i = 0; i < 16; i++) begin
				csd_q[i] <= BYTE_IDLE;
			end
		end else if (step) begin
			phase_q    <= phase_n;
			sub_q      <= sub_n;
			frame_q    <= frame_n;
			idx_q      <= idx_n;
			wait_q     <= wait_n;
			retry_q    <= retry_n;
			class_q    <= class_n;
			r1_q       <= r1_n;
			v2_q       <= v2_n;
			rep_out_q  <= rep_out_n;
			rep_kind_q <= rep_kind_n;
			rep_sec_q  <= rep_sec_n;
			if (csd_clr) begin
				for (int i = 0; i < 16; i++) begin
					csd_q[i] <= BYTE_IDLE;
				end
			end else if (csd_wr) begin
				csd_q[idx_q[3:0]] <= req.rx_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			ocr_q <= ocr_n;
		end
	end

endmodule

// ----- tb/tb_sd_spi_card_init_engine_core.sv -----
// Testbench for the SD card SPI init engine: card responder stimulus, predicted results, APB setup.
module tb_sd_spi_card_init_engine_core;
	import sdi_pkg::*;

	localparam int WAKE = 8;
	localparam longint CYCLE_LIMIT = 4000000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	req_t in_req;
	logic out_valid;
	logic out_ready;
	res_t out_res;
	logic psel;
	logic penable;
	logic pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	sd_spi_card_init_engine_core #(.WAKE_BYTES(WAKE)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
		.out_valid(out_valid), .out_ready(out_ready), .out_res(out_res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Predictor state.
	logic [15:0] lim_ready, lim_resp, lim_token;
	logic [7:0] lim_retry;
	phase_t ph;
	sub_t sb;
	logic [47:0] frame;
	int unsigned idx, wcnt, rcnt;
	logic [31:0] ocr;
	logic [7:0] csd [16];
	logic [2:0] kind;
	logic [7:0] r1;
	logic v2;
	logic [1:0] last_outcome;
	logic [2:0] last_kind;
	logic [32:0] last_sectors;

	req_t pending_reqs[$];
	res_t expected_results[$];
	int errors = 0;
	longint cycles = 0;
	int hold_off = 0;
	bit sender_pause = 0;

	function automatic int unsigned wrap16(logic [15:0] v);
		return v == 0 ? 65536 : v;
	endfunction

	function automatic int unsigned wrap8(logic [7:0] v);
		return v == 0 ? 256 : v;
	endfunction

	function automatic res_t xfer(logic [7:0] tx, logic cs);
		res_t r;
		r = '0;
		r.tx_byte = tx;
		r.chip_select = cs;
		return r;
	endfunction

	function automatic res_t status_result();
		res_t r;
		r.tx_byte = BYTE_IDLE;
		r.chip_select = 1'b1;
		r.done_res = 1'b1;
		r.outcome = last_outcome;
		r.card_kind = last_kind;
		r.sector_total = last_sectors;
		return r;
	endfunction

	function automatic res_t conclude(logic [1:0] oc, logic [2:0] k, logic [32:0] s);
		ph = PH_IDLE;
		last_outcome = oc;
		last_kind = k;
		last_sectors = s;
		if (oc != OUT_READY) kind = KIND_UNKNOWN;
		return status_result();
	endfunction

	function automatic logic [6:0] crc7_step(logic [6:0] c, logic [7:0] d);
		for (int i = 0; i < 8; i++) begin
			c = {c[5:0], 1'b0} ^ ((d[7] ^ c[6]) ? 7'h09 : 7'h00);
			d = d << 1;
		end
		return c;
	endfunction

	function automatic res_t issue(phase_t p, logic [5:0] cmd, logic [31:0] arg);
		logic [6:0] c;
		ph = p;
		frame = {2'b01, cmd, arg, 8'h00};
		c = '0;
		for (int k = 0; k < 5; k++) c = crc7_step(c, frame[47 - 8 * k -: 8]);
		frame[7:0] = {c, 1'b1};
		if (p == PH_CMD9) for (int i = 0; i < 16; i++) csd[i] = 8'hFF;
		sb = SB_READY;
		wcnt = wrap16(lim_ready);
		return xfer(BYTE_IDLE, 1'b0);
	endfunction

	function automatic logic [32:0] capacity();
		logic [32:0] v;
		int unsigned n;
		if (csd[0][7:6] == 2'b01) begin
			v = {csd[7][5:0], csd[8], csd[9]} + 1;
			return v << 10;
		end
		n = csd[5][3:0] + csd[10][7] + {csd[9][1:0], 1'b0} + 2;
		v = {csd[6][1:0], csd[7], csd[8][7:6]} + 1;
		if (n >= 9) return v << (n - 9);
		return v >> (9 - n);
	endfunction

	function automatic res_t command_finished();
		case (ph)
			PH_CMD0: begin
				if (r1 == 1) return issue(PH_CMD8, 6'd8, 32'h1AA);
				return conclude(OUT_NO_IDLE, KIND_UNKNOWN, 0);
			end
			PH_CMD8: begin
				if (r1 == 1) begin
					if (ocr[15:8] != 8'h01 || ocr[7:0] != CHECK_PAT)
						return conclude(OUT_IO_ERR, KIND_UNKNOWN, 0);
					v2 = 1;
				end else begin
					v2 = 0;
				end
				rcnt = wrap8(lim_retry);
				return issue(PH_A55, 6'd55, 0);
			end
			PH_A55: return issue(PH_A41, 6'd41, 32'h4000_0000);
			PH_A41: begin
				rcnt--;
				if (r1 == 0) begin
					if (v2) return issue(PH_CMD58, 6'd58, 32'h1AA);
					kind = KIND_SDV1;
					return issue(PH_CMD16, 6'd16, 512);
				end
				if (rcnt > 0) return issue(PH_A55, 6'd55, 0);
				if (v2) return conclude(OUT_IO_ERR, KIND_UNKNOWN, 0);
				rcnt = wrap8(lim_retry);
				return issue(PH_CMD1, 6'd1, 32'h4000_0000);
			end
			PH_CMD1: begin
				rcnt--;
				if (r1 == 0) begin
					kind = KIND_MMCV3;
					return issue(PH_CMD16, 6'd16, 512);
				end
				if (rcnt > 0) return issue(PH_CMD1, 6'd1, 32'h4000_0000);
				return conclude(OUT_IO_ERR, KIND_UNKNOWN, 0);
			end
			PH_CMD58: begin
				if (r1 != 0) return conclude(OUT_IO_ERR, KIND_UNKNOWN, 0);
				if (ocr[30]) begin
					kind = KIND_SDV2_BLK;
					return issue(PH_CMD9, 6'd9, 0);
				end
				kind = KIND_SDV2_BYTE;
				return issue(PH_CMD16, 6'd16, 512);
			end
			PH_CMD16: return issue(PH_CMD9, 6'd9, 0);
			default: return conclude(OUT_READY, kind, capacity());
		endcase
	endfunction

	function automatic res_t exchange_step(logic [7:0] rx);
		case (sb)
			SB_READY: begin
				wcnt--;
				if (rx != BYTE_IDLE && wcnt > 0) return xfer(BYTE_IDLE, 1'b0);
				sb = SB_FRAME;
				idx = 1;
				return xfer(frame[47:40], 1'b0);
			end
			SB_FRAME: begin
				if (idx < 6) begin
					idx++;
					return xfer(frame[47 - 8 * (idx - 1) -: 8], 1'b0);
				end
				sb = SB_RESP;
				wcnt = wrap16(lim_resp);
				return xfer(BYTE_IDLE, 1'b0);
			end
			SB_RESP: begin
				wcnt--;
				if (rx[7] && wcnt > 0) return xfer(BYTE_IDLE, 1'b0);
				r1 = rx;
				if (ph == PH_CMD8 || ph == PH_CMD58) begin
					sb = SB_RSP;
					idx = 0;
					return xfer(BYTE_IDLE, 1'b0);
				end
				if (ph == PH_CMD9) begin
					sb = SB_TOKEN;
					wcnt = wrap16(lim_token);
					return xfer(BYTE_IDLE, 1'b0);
				end
				return command_finished();
			end
			SB_RSP: begin
				ocr = {ocr[23:0], rx};
				idx++;
				if (idx < 4) return xfer(BYTE_IDLE, 1'b0);
				sb = SB_DUMMY;
				idx = 0;
				return xfer(BYTE_IDLE, 1'b0);
			end
			SB_TOKEN: begin
				wcnt--;
				if (rx == BYTE_IDLE && wcnt > 0) return xfer(BYTE_IDLE, 1'b0);
				if (rx == BYTE_TOKEN) begin
					sb = SB_DATA;
					idx = 0;
					return xfer(BYTE_IDLE, 1'b0);
				end
				return command_finished();
			end
			SB_DATA: begin
				csd[idx[3:0]] = rx;
				idx++;
				if (idx < 16) return xfer(BYTE_IDLE, 1'b0);
				sb = SB_CRC;
				idx = 0;
				return xfer(BYTE_IDLE, 1'b0);
			end
			default: begin
				idx++;
				if (idx < 2) return xfer(BYTE_IDLE, 1'b0);
				return command_finished();
			end
		endcase
	endfunction

	function automatic res_t predict_card_step(req_t q);
		if (q.op == OP_START) begin
			kind = KIND_UNKNOWN;
			ph = PH_WAKE;
			idx = 1;
			return xfer(BYTE_IDLE, 1'b1);
		end
		if (ph == PH_IDLE) return status_result();
		if (ph == PH_WAKE) begin
			if (idx < WAKE) begin
				idx++;
				return xfer(BYTE_IDLE, 1'b1);
			end
			return issue(PH_CMD0, 6'd0, 0);
		end
		return exchange_step(q.rx_byte);
	endfunction

	function automatic int short_or_long_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Sender.
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_req <= '0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(predict_card_step(in_req));
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() > 0 && !sender_pause) begin
					in_valid <= 1'b1;
					in_req <= pending_reqs.pop_front();
					send_gap = short_or_long_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver and checker.
	int recv_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		res_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("sd_spi_card_init_engine_core verification failed");
				$finish;
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result %p", $time, out_res);
					errors++;
				end else begin
					e = expected_results.pop_front();
					if (e !== out_res) begin
						$display("%0t: expected %p actual %p", $time, e, out_res);
						errors++;
					end
				end
			end
			if (hold_off > 0) begin
				hold_off--;
				out_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				recv_gap = short_or_long_gap();
			end
		end
	end

	// Card model used to build stimulus.
	task automatic push(logic op, logic [7:0] b);
		req_t q;
		q.op = op;
		q.rx_byte = b;
		pending_reqs.push_back(q);
	endtask

	task automatic push_noise(int n);
		for (int i = 0; i < n; i++) push(1'($urandom_range(0, 9) != 0), 8'($urandom));
	endtask

	// Bytes for one command: ready polls, frame, then response.
	task automatic push_command(logic [7:0] resp, int busy_polls, int resp_delay);
		for (int i = 0; i < busy_polls; i++) push(OP_REPORT, 8'($urandom_range(0, 254)));
		push(OP_REPORT, BYTE_IDLE);
		for (int i = 0; i < 6; i++) push(OP_REPORT, 8'($urandom));
		for (int i = 0; i < resp_delay; i++) push(OP_REPORT, 8'h80 | 8'($urandom));
		push(OP_REPORT, resp);
	endtask

	task automatic push_trailer(logic [31:0] word);
		for (int i = 0; i < 4; i++) push(OP_REPORT, word[31 - 8 * i -: 8]);
		push(OP_REPORT, 8'($urandom));
		push(OP_REPORT, 8'($urandom));
	endtask

	task automatic push_csd(bit v2csd);
		logic [7:0] b;
		push(OP_REPORT, BYTE_TOKEN);
		for (int i = 0; i < 16; i++) begin
			b = 8'($urandom);
			if (i == 0) b[7:6] = v2csd ? 2'b01 : 2'b00;
			push(OP_REPORT, b);
		end
		push(OP_REPORT, 8'($urandom));
		push(OP_REPORT, 8'($urandom));
	endtask

	// One start sequence; kind_sel picks card type, bad adds faults.
	task automatic push_sequence(int kind_sel, bit bad);
		int fails;
		int q;
		push(OP_START, 8'($urandom));
		for (int i = 0; i < WAKE; i++) push(OP_REPORT, 8'($urandom));
		q = $urandom_range(0, 2);
		if (bad && $urandom_range(0, 3) == 0) begin
			push_command(8'($urandom_range(0, 127)), q, q);
			return;
		end
		push_command(8'h01, q, q);
		if (kind_sel >= 2 && kind_sel <= 3) begin
			push_command(8'h01, 0, $urandom_range(0, 1));
			if (bad && $urandom_range(0, 2) == 0) begin
				push_trailer({16'($urandom), 16'($urandom)});
			end else begin
				push_trailer({16'($urandom), 8'h01, CHECK_PAT});
			end
		end else begin
			push_command(8'h05, 0, 0);
		end
		fails = $urandom_range(0, 2);
		for (int i = 0; i < fails; i++) begin
			push_command(8'h01, 0, 0);
			push_command(8'h01, 0, 0);
		end
		push_command(8'h00, 0, 0);
		if (kind_sel == 4 || (bad && $urandom_range(0, 2) == 0)) begin
			push_command(8'h01, 0, 0);
		end
		push_command(8'h00, 0, 0);
		if (kind_sel >= 2 && kind_sel <= 3) begin
			push_trailer({1'b1, kind_sel == 3, 30'($urandom)});
			push_command(8'h00, 0, 0);
		end
		push_command(8'($urandom_range(0, 1)), 0, 0);
		push_command(8'h00, 0, 0);
		if (bad && $urandom_range(0, 2) == 0) begin
			push(OP_REPORT, BYTE_IDLE);
			push(OP_REPORT, 8'($urandom_range(0, 253)));
		end else begin
			push_csd(kind_sel == 3 ? 1'b1 : 1'($urandom));
		end
		push(OP_REPORT, 8'($urandom));
	endtask

	task automatic apb_write(logic [1:0] r, logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (r)
			REG_READY_LIM: lim_ready = v[15:0];
			REG_RESP_LIM:  lim_resp = v[15:0];
			REG_RETRY_LIM: lim_retry = v[7:0];
			default:       lim_token = v[15:0];
		endcase
	endtask

	task automatic settle();
		while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_limits(logic [15:0] a, logic [15:0] b, logic [7:0] c, logic [15:0] d);
		settle();
		apb_write(REG_READY_LIM, a);
		apb_write(REG_RESP_LIM, b);
		apb_write(REG_RETRY_LIM, c);
		apb_write(REG_TOKEN_LIM, d);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		lim_ready = 100;
		lim_resp = 1000;
		lim_retry = 32;
		lim_token = 100;
		ph = PH_IDLE;
		sb = SB_READY;
		frame = '0;
		idx = 0;
		wcnt = 0;
		rcnt = 0;
		ocr = '0;
		for (int i = 0; i < 16; i++) csd[i] = 8'hFF;
		kind = KIND_UNKNOWN;
		r1 = '0;
		v2 = 0;
		last_outcome = OUT_NO_IDLE;
		last_kind = KIND_UNKNOWN;
		last_sectors = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: report before any start, clean runs of each card type.
		push(OP_REPORT, 8'h00);
		push(OP_REPORT, 8'hFF);
		for (int k = 1; k <= 4; k++) push_sequence(k, 0);
		push(OP_START, 8'h00);
		push(OP_REPORT, 8'h00);
		push(OP_START, 8'hFF);
		push_noise(4);

		// Tiny limits: timeouts and init with one or two attempts.
		set_limits(16'd1, 16'd1, 8'd1, 16'd1);
		for (int i = 0; i < 2; i++) push_sequence($urandom_range(1, 4), 1);
		push_noise(30);
		set_limits(16'd2, 16'd3, 8'd2, 16'd2);
		for (int i = 0; i < 2; i++) push_sequence($urandom_range(1, 4), 1);

		// Maximum and wrap values with well-behaved cards.
		set_limits(16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
		push_sequence($urandom_range(1, 4), 0);
		set_limits(16'd0, 16'd0, 8'd0, 16'd0);
		push_sequence($urandom_range(1, 4), 0);

		// Receiver stall while the sender keeps going.
		set_limits(16'd100, 16'd1000, 8'd32, 16'd100);
		hold_off = 300;
		push_sequence($urandom_range(1, 4), 0);

		// Sender pause until every result is in.
		sender_pause = 1;
		while (expected_results.size() > 0 || in_valid) @(posedge clk);
		sender_pause = 0;

		for (int i = 0; i < 2; i++) begin
			push_sequence($urandom_range(1, 4), $urandom_range(0, 2) == 0);
			if ($urandom_range(0, 4) == 0) push_noise($urandom_range(1, 12));
		end

		settle();
		if (errors == 0 && expected_results.size() == 0) begin
			$display("sd_spi_card_init_engine_core verification clean");
		end else begin
			$display("sd_spi_card_init_engine_core verification failed");
		end
		$finish;
	end
endmodule
